// ----- rtl/core/plane_pair_intersection_line_defines.svh -----
// Assertion macros for the plane pair intersection checker.
// No dependencies; included by the checker file only.
`ifndef PLANE_PAIR_INTERSECTION_LINE_DEFINES_SVH
`define PLANE_PAIR_INTERSECTION_LINE_DEFINES_SVH

// Implication checked at every clock edge outside reset.
`define PPIL_ASSERT_IMPL(lbl, ante, cons, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// Condition that must never hold outside reset.
`define PPIL_ASSERT_NEVER(lbl, cond, msg) \
    lbl: assert property (@(posedge clk) disable iff (!rst_n) !(cond)) \
        else $error(msg);

`endif

// ----- rtl/core/ppil_pkg.sv -----
// Shared constants for the plane pair intersection line block.
// No dependencies; used by the top level and its checker.
package ppil_pkg;

    localparam logic [1:0] STATUS_OK       = 2'd0;
    localparam logic [1:0] STATUS_PARALLEL = 2'd1;
    localparam logic [1:0] STATUS_SINGULAR = 2'd2;

    localparam logic [31:0] EPS_RESET = 32'd1678;

    // quotient bits resolved one per divider stage
    localparam int DIV_STEPS = 32;

    // eight front stages, the divider stages and the output register
    localparam int LATENCY = 8 + DIV_STEPS + 1;

endpackage

// ----- rtl/core/plane_pair_intersection_line.sv -----
// Throughput: one word per cycle; busy stays low, so start may be held every cycle.
// Eight arithmetic stages feed a 32-stage restoring divider, one quotient bit per stage.
// Reset clears all valid bits and sets eps_reg to 1678; payload is not reset.
// Depends on ppil_pkg.
module plane_pair_intersection_line (
    input  logic                clk,
    input  logic                rst_n,
    input  logic                start,
    output logic                busy,
    input  logic                cfg_we,
    input  logic [31:0]         cfg_wdata,
    input  logic signed [15:0]  first_normal_x,
    input  logic signed [15:0]  first_normal_y,
    input  logic signed [15:0]  first_normal_z,
    input  logic signed [23:0]  first_offset,
    input  logic signed [15:0]  second_normal_x,
    input  logic signed [15:0]  second_normal_y,
    input  logic signed [15:0]  second_normal_z,
    input  logic signed [23:0]  second_offset,
    output logic                done,
    output logic [1:0]          status,
    output logic signed [31:0]  line_point_x,
    output logic signed [31:0]  line_point_y,
    output logic signed [31:0]  line_point_z,
    output logic signed [33:0]  line_dir_x,
    output logic signed [33:0]  line_dir_y,
    output logic signed [33:0]  line_dir_z
);

    localparam int NS = ppil_pkg::DIV_STEPS;

    logic [31:0] eps_reg;

    // stage valid bits
    logic s1_vld_reg, s2_vld_reg, s3_vld_reg, s4_vld_reg;
    logic s5_vld_reg, s6_vld_reg, s7_vld_reg;
    logic div_vld_reg [0:NS];
    logic done_reg;

    // stage 1: raw products
    logic signed [15:0] s1_n0_reg [0:2];
    logic signed [15:0] s1_n1_reg [0:2];
    logic signed [23:0] s1_d0_reg, s1_d1_reg;
    logic signed [31:0] s1_aybz_reg, s1_azby_reg, s1_azbx_reg;
    logic signed [31:0] s1_axbz_reg, s1_axby_reg, s1_aybx_reg;
    logic signed [31:0] s1_aa_reg [0:2];
    logic signed [31:0] s1_ab_reg [0:2];
    logic signed [31:0] s1_bb_reg [0:2];

    // stage 2: cross product and Gram entries
    logic signed [15:0] s2_n0_reg [0:2];
    logic signed [15:0] s2_n1_reg [0:2];
    logic signed [23:0] s2_d0_reg, s2_d1_reg;
    logic signed [33:0] s2_dir_reg [0:2];
    logic signed [33:0] s2_n00_reg, s2_n01_reg, s2_n11_reg;

    // stage 3: squares and offset products
    logic signed [15:0] s3_n0_reg [0:2];
    logic signed [15:0] s3_n1_reg [0:2];
    logic signed [33:0] s3_dir_reg [0:2];
    logic [63:0]        s3_sq_reg [0:2];
    logic signed [57:0] s3_n11d0_reg, s3_n01d1_reg, s3_n00d1_reg, s3_n01d0_reg;

    // stage 4: determinant and point coefficients
    logic signed [15:0] s4_n0_reg [0:2];
    logic signed [15:0] s4_n1_reg [0:2];
    logic signed [33:0] s4_dir_reg [0:2];
    logic [63:0]        s4_det_reg;
    logic signed [58:0] s4_a_reg, s4_b_reg;

    // stage 5: numerator products and parallel test
    logic signed [33:0] s5_dir_reg [0:2];
    logic [63:0]        s5_det_reg;
    logic               s5_par_reg;
    logic signed [74:0] s5_pa_reg [0:2];
    logic signed [74:0] s5_pb_reg [0:2];

    // stage 6: signed numerators
    logic signed [33:0] s6_dir_reg [0:2];
    logic [63:0]        s6_det_reg;
    logic               s6_par_reg;
    logic signed [75:0] s6_num_reg [0:2];

    // stage 7: magnitudes
    logic signed [33:0] s7_dir_reg [0:2];
    logic [63:0]        s7_det_reg;
    logic               s7_par_reg;
    logic [75:0]        s7_mag_reg [0:2];
    logic               s7_neg_reg [0:2];

    // divider pipeline; element 0 is loaded by stage 8
    logic signed [33:0] div_dir_reg [0:NS][0:2];
    logic [63:0]        div_det_reg [0:NS];
    logic               div_par_reg [0:NS];
    logic [63:0]        div_rem_reg [0:NS][0:2];
    logic [31:0]        div_low_reg [0:NS][0:2];
    logic [31:0]        div_quo_reg [0:NS][0:2];
    logic               div_sat_reg [0:NS][0:2];
    logic               div_neg_reg [0:NS][0:2];

    logic [64:0] div_trial [0:NS-1][0:2];
    logic [64:0] div_diff  [0:NS-1][0:2];

    logic [1:0]         status_reg;
    logic signed [31:0] point_reg [0:2];
    logic signed [33:0] dir_reg   [0:2];

    logic [31:0] point_next [0:2];

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            eps_reg    <= ppil_pkg::EPS_RESET;
            s1_vld_reg <= 1'b0;
            s2_vld_reg <= 1'b0;
            s3_vld_reg <= 1'b0;
            s4_vld_reg <= 1'b0;
            s5_vld_reg <= 1'b0;
            s6_vld_reg <= 1'b0;
            s7_vld_reg <= 1'b0;
            for (int g = 0; g <= NS; g++)
            begin
                div_vld_reg[g] <= 1'b0;
            end
            done_reg <= 1'b0;
        end
        else
        begin
            if (cfg_we)
            begin
                eps_reg <= cfg_wdata;
            end
            s1_vld_reg     <= start;
            s2_vld_reg     <= s1_vld_reg;
            s3_vld_reg     <= s2_vld_reg;
            s4_vld_reg     <= s3_vld_reg;
            s5_vld_reg     <= s4_vld_reg;
            s6_vld_reg     <= s5_vld_reg;
            s7_vld_reg     <= s6_vld_reg;
            div_vld_reg[0] <= s7_vld_reg;
            for (int g = 0; g < NS; g++)
            begin
                div_vld_reg[g+1] <= div_vld_reg[g];
            end
            done_reg <= div_vld_reg[NS];
        end
    end

    // one restoring step per stage: trial remainder against the determinant
    always_comb
    begin
        for (int g = 0; g < NS; g++)
        begin
            for (int c = 0; c < 3; c++)
            begin
                div_trial[g][c] = {div_rem_reg[g][c], div_low_reg[g][c][31]};
                div_diff[g][c]  = div_trial[g][c] - {1'b0, div_det_reg[g]};
            end
        end
    end

    // truncate toward zero, saturate to Q14.18
    always_comb
    begin
        for (int c = 0; c < 3; c++)
        begin
            if (div_sat_reg[NS][c] ||
                (div_neg_reg[NS][c] ? (div_quo_reg[NS][c] > 32'h8000_0000)
                                    : div_quo_reg[NS][c][31]))
            begin
                point_next[c] = div_neg_reg[NS][c] ? 32'h8000_0000 : 32'h7FFF_FFFF;
            end
            else if (div_neg_reg[NS][c])
            begin
                point_next[c] = 32'd0 - div_quo_reg[NS][c];
            end
            else
            begin
                point_next[c] = div_quo_reg[NS][c];
            end
        end
    end

    always_ff @(posedge clk)
    begin
        // stage 1
        s1_n0_reg[0] <= first_normal_x;
        s1_n0_reg[1] <= first_normal_y;
        s1_n0_reg[2] <= first_normal_z;
        s1_n1_reg[0] <= second_normal_x;
        s1_n1_reg[1] <= second_normal_y;
        s1_n1_reg[2] <= second_normal_z;
        s1_d0_reg    <= first_offset;
        s1_d1_reg    <= second_offset;
        s1_aybz_reg  <= first_normal_y * second_normal_z;
        s1_azby_reg  <= first_normal_z * second_normal_y;
        s1_azbx_reg  <= first_normal_z * second_normal_x;
        s1_axbz_reg  <= first_normal_x * second_normal_z;
        s1_axby_reg  <= first_normal_x * second_normal_y;
        s1_aybx_reg  <= first_normal_y * second_normal_x;
        s1_aa_reg[0] <= first_normal_x * first_normal_x;
        s1_aa_reg[1] <= first_normal_y * first_normal_y;
        s1_aa_reg[2] <= first_normal_z * first_normal_z;
        s1_ab_reg[0] <= first_normal_x * second_normal_x;
        s1_ab_reg[1] <= first_normal_y * second_normal_y;
        s1_ab_reg[2] <= first_normal_z * second_normal_z;
        s1_bb_reg[0] <= second_normal_x * second_normal_x;
        s1_bb_reg[1] <= second_normal_y * second_normal_y;
        s1_bb_reg[2] <= second_normal_z * second_normal_z;

        // stage 2
        s2_n0_reg     <= s1_n0_reg;
        s2_n1_reg     <= s1_n1_reg;
        s2_d0_reg     <= s1_d0_reg;
        s2_d1_reg     <= s1_d1_reg;
        s2_dir_reg[0] <= 34'(s1_aybz_reg) - 34'(s1_azby_reg);
        s2_dir_reg[1] <= 34'(s1_azbx_reg) - 34'(s1_axbz_reg);
        s2_dir_reg[2] <= 34'(s1_axby_reg) - 34'(s1_aybx_reg);
        s2_n00_reg    <= 34'(s1_aa_reg[0]) + 34'(s1_aa_reg[1]) + 34'(s1_aa_reg[2]);
        s2_n01_reg    <= 34'(s1_ab_reg[0]) + 34'(s1_ab_reg[1]) + 34'(s1_ab_reg[2]);
        s2_n11_reg    <= 34'(s1_bb_reg[0]) + 34'(s1_bb_reg[1]) + 34'(s1_bb_reg[2]);

        // stage 3
        s3_n0_reg  <= s2_n0_reg;
        s3_n1_reg  <= s2_n1_reg;
        s3_dir_reg <= s2_dir_reg;
        for (int c = 0; c < 3; c++)
        begin
            s3_sq_reg[c] <= 64'(s2_dir_reg[c][33] ? 32'(-s2_dir_reg[c]) : s2_dir_reg[c][31:0])
                          * 64'(s2_dir_reg[c][33] ? 32'(-s2_dir_reg[c]) : s2_dir_reg[c][31:0]);
        end
        s3_n11d0_reg <= s2_n11_reg * s2_d0_reg;
        s3_n01d1_reg <= s2_n01_reg * s2_d1_reg;
        s3_n00d1_reg <= s2_n00_reg * s2_d1_reg;
        s3_n01d0_reg <= s2_n01_reg * s2_d0_reg;

        // stage 4: the squared cross length equals the Gram determinant
        s4_n0_reg  <= s3_n0_reg;
        s4_n1_reg  <= s3_n1_reg;
        s4_dir_reg <= s3_dir_reg;
        s4_det_reg <= s3_sq_reg[0] + s3_sq_reg[1] + s3_sq_reg[2];
        s4_a_reg   <= 59'(s3_n11d0_reg) - 59'(s3_n01d1_reg);
        s4_b_reg   <= 59'(s3_n00d1_reg) - 59'(s3_n01d0_reg);

        // stage 5
        s5_dir_reg <= s4_dir_reg;
        s5_det_reg <= s4_det_reg;
        s5_par_reg <= (s4_det_reg == 64'd0) || (s4_det_reg < {eps_reg, 32'd0});
        for (int c = 0; c < 3; c++)
        begin
            s5_pa_reg[c] <= s4_n0_reg[c] * s4_a_reg;
            s5_pb_reg[c] <= s4_n1_reg[c] * s4_b_reg;
        end

        // stage 6
        s6_dir_reg <= s5_dir_reg;
        s6_det_reg <= s5_det_reg;
        s6_par_reg <= s5_par_reg;
        for (int c = 0; c < 3; c++)
        begin
            s6_num_reg[c] <= 76'(s5_pa_reg[c]) + 76'(s5_pb_reg[c]);
        end

        // stage 7
        s7_dir_reg <= s6_dir_reg;
        s7_det_reg <= s6_det_reg;
        s7_par_reg <= s6_par_reg;
        for (int c = 0; c < 3; c++)
        begin
            s7_neg_reg[c] <= s6_num_reg[c][75];
            s7_mag_reg[c] <= s6_num_reg[c][75] ? 76'(-s6_num_reg[c]) : 76'(s6_num_reg[c]);
        end

        // stage 8: the dividend is mag * 2^18; its bits above 32 form the first
        // remainder, and a quotient of 2^32 or more saturates
        div_dir_reg[0] <= s7_dir_reg;
        div_det_reg[0] <= s7_det_reg;
        div_par_reg[0] <= s7_par_reg;
        for (int c = 0; c < 3; c++)
        begin
            div_rem_reg[0][c] <= {2'b00, s7_mag_reg[c][75:14]};
            div_low_reg[0][c] <= {s7_mag_reg[c][13:0], 18'd0};
            div_quo_reg[0][c] <= 32'd0;
            div_sat_reg[0][c] <= {2'b00, s7_mag_reg[c][75:14]} >= s7_det_reg;
            div_neg_reg[0][c] <= s7_neg_reg[c];
        end

        // divider stages
        for (int g = 0; g < NS; g++)
        begin
            div_dir_reg[g+1] <= div_dir_reg[g];
            div_det_reg[g+1] <= div_det_reg[g];
            div_par_reg[g+1] <= div_par_reg[g];
            for (int c = 0; c < 3; c++)
            begin
                div_rem_reg[g+1][c] <= div_diff[g][c][64] ? div_trial[g][c][63:0]
                                                          : div_diff[g][c][63:0];
                div_low_reg[g+1][c] <= {div_low_reg[g][c][30:0], 1'b0};
                div_quo_reg[g+1][c] <= {div_quo_reg[g][c][30:0], !div_diff[g][c][64]};
                div_sat_reg[g+1][c] <= div_sat_reg[g][c];
                div_neg_reg[g+1][c] <= div_neg_reg[g][c];
            end
        end

        // output register; the point reads zero for parallel planes
        status_reg <= div_par_reg[NS] ? ppil_pkg::STATUS_PARALLEL : ppil_pkg::STATUS_OK;
        dir_reg    <= div_dir_reg[NS];
        for (int c = 0; c < 3; c++)
        begin
            point_reg[c] <= div_par_reg[NS] ? 32'sd0 : $signed(point_next[c]);
        end
    end

    assign busy         = 1'b0;
    assign done         = done_reg;
    assign status       = status_reg;
    assign line_point_x = point_reg[0];
    assign line_point_y = point_reg[1];
    assign line_point_z = point_reg[2];
    assign line_dir_x   = dir_reg[0];
    assign line_dir_y   = dir_reg[1];
    assign line_dir_z   = dir_reg[2];

endmodule

// ----- rtl/core/ppil_checker.sv -----
// Port-level checker for plane_pair_intersection_line, bound to the top level.
// Depends on ppil_pkg and plane_pair_intersection_line_defines.svh.
`include "plane_pair_intersection_line_defines.svh"

module ppil_checker (
    input logic                clk,
    input logic                rst_n,
    input logic                start,
    input logic                busy,
    input logic                done,
    input logic [1:0]          status,
    input logic signed [31:0]  line_point_x,
    input logic signed [31:0]  line_point_y,
    input logic signed [31:0]  line_point_z,
    input logic signed [33:0]  line_dir_x,
    input logic signed [33:0]  line_dir_y,
    input logic signed [33:0]  line_dir_z
);

    // every word out traces back to a start a fixed latency earlier
    `PPIL_ASSERT_IMPL(a_done_from_start, done, $past(start, ppil_pkg::LATENCY), "done without start")
    `PPIL_ASSERT_IMPL(a_status_code, done, (status == ppil_pkg::STATUS_OK) || (status == ppil_pkg::STATUS_PARALLEL), "singular or bad status")
    `PPIL_ASSERT_IMPL(a_parallel_point, done && (status == ppil_pkg::STATUS_PARALLEL), (line_point_x == 0) && (line_point_y == 0) && (line_point_z == 0), "parallel point not zero")
    `PPIL_ASSERT_IMPL(a_zero_dir, done && (line_dir_x == 0) && (line_dir_y == 0) && (line_dir_z == 0), status == ppil_pkg::STATUS_PARALLEL, "zero direction not parallel")
    `PPIL_ASSERT_NEVER(a_never_busy, busy, "busy raised")

endmodule

bind plane_pair_intersection_line ppil_checker u_ppil_checker (.*);
